### sv/set_assoc_cache_tag_lru_top_defines.svh
// assertion macros for the cache tag and lru engine
`ifndef SET_ASSOC_CACHE_TAG_LRU_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LRU_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SACL_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sacl: same-cycle check failed");
// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sacl: next-cycle check failed");
`else
`define SACL_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SACL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### sv/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

   localparam int SETS       = 64;
   localparam int WAYS       = 8;
   localparam int LINE_BYTES = 64;
   localparam int ADDR_BITS  = 48;

   localparam int OFF_W      = $clog2(LINE_BYTES);
   localparam int SET_W      = $clog2(SETS);
   localparam int TAG_W      = ADDR_BITS - OFF_W;
   localparam int WAY_W      = 3;
   localparam int IB_W       = 3;
   localparam int STAMP_W    = 32;
   localparam int MODE_W     = 3;
   localparam int RSP_DATA_W = 56;

   localparam logic [IB_W-1:0] IB_RESET = IB_W'(SET_W);

   typedef enum logic [MODE_W-1:0] {
      MODE_LOOKUP     = 3'd0,
      MODE_FILL       = 3'd1,
      MODE_INVALIDATE = 3'd2,
      MODE_FLUSH_SET  = 3'd3,
      MODE_MARK_DIRTY = 3'd4
   } mode_type;

   typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_type;

   // one set worth of tag state
   typedef struct packed {
      tag_row_type                    tag;
      logic [WAYS-1:0][STAMP_W-1:0]   age;
      logic [WAYS-1:0]                valid;
      logic [WAYS-1:0]                dirty;
   } row_type;

   // first result of an item plus what is left of a flush
   typedef struct packed {
      logic                  hit;
      logic [WAY_W-1:0]      way;
      logic                  wb_valid;
      logic [ADDR_BITS-1:0]  wb_addr;
      logic [WAYS-1:0]       rest;
      logic [SET_W-1:0]      set_idx;
      logic [IB_W-1:0]       ib;
   } rsp_load_type;

   // lowest set bit of a way mask
   function automatic logic [WAY_W-1:0] first_one(input logic [WAYS-1:0] mask);
      logic [WAY_W-1:0] r;
      r = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (mask[w]) begin
            r = WAY_W'(w);
         end
      end
      return r;
   endfunction

   // line start address rebuilt from a stored tag and the set
   function automatic logic [ADDR_BITS-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                      input logic [SET_W-1:0] set_idx,
                                                      input logic [IB_W-1:0]  ib);
      logic [ADDR_BITS-1:0] t;
      logic [ADDR_BITS-1:0] s;
      t = {tag, {OFF_W{1'b0}}} << ib;
      s = ADDR_BITS'({set_idx, {OFF_W{1'b0}}});
      return t | s;
   endfunction

endpackage

`default_nettype wire

### sv/sacl_row_ram.sv
`default_nettype none

module sacl_row_ram
   import sacl_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [SET_W-1:0]  rd_addr,
   output row_type                rd_row,
   input  wire logic              wr_en,
   input  wire logic [SET_W-1:0]  wr_addr,
   input  wire row_type           wr_row
);

   row_type           mem [SETS];
   row_type           data_ff;
   logic [SETS-1:0]   init_ff;
   logic              rd_init_ff;
   logic              same_row;

   assign same_row = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   // write-first so a back to back item on the same set sees the update
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (same_row) begin
            data_ff <= wr_row;
         end else begin
            data_ff <= mem[rd_addr];
         end
      end
   end

   // row written flags, an unwritten row reads as all clear
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff    <= '0;
         rd_init_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            init_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_init_ff <= same_row | init_ff[rd_addr];
         end
      end
   end

   assign rd_row = rd_init_ff ? data_ff : '0;

endmodule

`default_nettype wire

### sv/sacl_policy.sv
`default_nettype none

module sacl_policy
   import sacl_pkg::*;
(
   input  wire mode_type             mode,
   input  wire logic [TAG_W-1:0]     tag,
   input  wire logic [SET_W-1:0]     set_idx,
   input  wire logic [IB_W-1:0]      ib,
   input  wire logic [STAMP_W-1:0]   stamp,
   input  wire row_type              row,
   output row_type                   new_row,
   output rsp_load_type              ld
);

   localparam int NODES = 1 << WAY_W;

   logic [WAYS-1:0]     hit_vec;
   logic                any_hit;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    inv_way;
   logic [WAY_W-1:0]    victim;
   logic [WAYS-1:0]     dirty_mask;
   logic [WAY_W-1:0]    dirty_way;
   logic [STAMP_W-1:0]  node_age [2*NODES-1];
   logic [WAY_W-1:0]    node_way [2*NODES-1];

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = row.valid[w] && (row.tag[w] == tag);
      end
   end

   assign any_hit    = |hit_vec;
   assign hit_way    = first_one(hit_vec);
   assign inv_way    = first_one(~row.valid);
   assign dirty_mask = row.valid & row.dirty;
   assign dirty_way  = first_one(dirty_mask);

   // oldest stamp, tie goes to the lower way
   always_comb begin
      for (int i = 0; i < NODES; i++) begin
         if (i < WAYS) begin
            node_age[NODES-1+i] = row.age[i];
         end else begin
            node_age[NODES-1+i] = '1;
         end
         node_way[NODES-1+i] = WAY_W'(i);
      end
      for (int i = NODES - 2; i >= 0; i--) begin
         if (node_age[2*i+2] < node_age[2*i+1]) begin
            node_age[i] = node_age[2*i+2];
            node_way[i] = node_way[2*i+2];
         end else begin
            node_age[i] = node_age[2*i+1];
            node_way[i] = node_way[2*i+1];
         end
      end
   end

   assign victim = (&row.valid) ? node_way[0] : inv_way;

   always_comb begin
      new_row    = row;
      ld         = '0;
      ld.set_idx = set_idx;
      ld.ib      = ib;
      case (mode)
         MODE_LOOKUP, MODE_MARK_DIRTY: begin
            if (any_hit) begin
               new_row.age[hit_way] = stamp;
               if (mode == MODE_MARK_DIRTY) begin
                  new_row.dirty[hit_way] = 1'b1;
               end
               ld.hit = 1'b1;
               ld.way = hit_way;
            end
         end
         MODE_FILL: begin
            if (any_hit) begin
               new_row.age[hit_way] = stamp;
               ld.hit = 1'b1;
               ld.way = hit_way;
            end else begin
               ld.way = victim;
               if ((&row.valid) && row.dirty[victim]) begin
                  ld.wb_valid = 1'b1;
                  ld.wb_addr  = line_addr(row.tag[victim], set_idx, ib);
               end
               new_row.tag[victim]   = tag;
               new_row.valid[victim] = 1'b1;
               new_row.dirty[victim] = 1'b0;
               new_row.age[victim]   = stamp;
            end
         end
         MODE_INVALIDATE: begin
            if (any_hit) begin
               ld.hit = 1'b1;
               ld.way = hit_way;
               if (row.dirty[hit_way]) begin
                  ld.wb_valid = 1'b1;
                  ld.wb_addr  = line_addr(tag, set_idx, ib);
               end
               new_row.valid[hit_way] = 1'b0;
               new_row.dirty[hit_way] = 1'b0;
            end
         end
         MODE_FLUSH_SET: begin
            if (|dirty_mask) begin
               ld.way      = dirty_way;
               ld.wb_valid = 1'b1;
               ld.wb_addr  = line_addr(row.tag[dirty_way], set_idx, ib);
               ld.rest     = dirty_mask & (dirty_mask - WAYS'(1));
            end
            new_row.valid = '0;
            new_row.dirty = '0;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### sv/sacl_rsp_queue.sv
`default_nettype none

module sacl_rsp_queue
   import sacl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire rsp_load_type           ld,
   input  wire tag_row_type            ld_tags,
   output logic                        free,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast
);

   logic                  valid_ff;
   logic                  hit_ff;
   logic [WAY_W-1:0]      way_ff;
   logic                  wbv_ff;
   logic [ADDR_BITS-1:0]  wba_ff;
   logic [WAYS-1:0]       rest_ff;
   tag_row_type           tags_ff;
   logic [SET_W-1:0]      set_ff;
   logic [IB_W-1:0]       ib_ff;
   logic                  pop;
   logic [WAY_W-1:0]      next_way;

   assign pop      = valid_ff && rsp_tready;
   assign free     = !valid_ff || (pop && (rest_ff == '0));
   assign next_way = first_one(rest_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rest_ff  <= '0;
      end else if (load) begin
         valid_ff <= 1'b1;
         rest_ff  <= ld.rest;
      end else if (pop) begin
         if (rest_ff != '0) begin
            rest_ff <= rest_ff & (rest_ff - WAYS'(1));
         end else begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff  <= ld.hit;
         way_ff  <= ld.way;
         wbv_ff  <= ld.wb_valid;
         wba_ff  <= ld.wb_addr;
         tags_ff <= ld_tags;
         set_ff  <= ld.set_idx;
         ib_ff   <= ld.ib;
      end else if (pop && (rest_ff != '0)) begin
         hit_ff <= 1'b0;
         way_ff <= next_way;
         wbv_ff <= 1'b1;
         wba_ff <= line_addr(tags_ff[next_way], set_ff, ib_ff);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = (rest_ff == '0);
   assign rsp_tdata  = {{(RSP_DATA_W-ADDR_BITS-WAY_W-2){1'b0}}, wba_ff, wbv_ff, way_ff, hit_ff};

endmodule

`default_nettype wire

### sv/set_assoc_cache_tag_lru_top.sv
// channel  dir  handshake                payload
// req      in   req_tvalid/req_tready    tuser mode, tdata address
// rsp      out  rsp_tvalid/rsp_tready    tdata hit/way/writeback, tlast
// csr      in   csr_valid/csr_ready      csr_data index_bits
//
// one item per cycle while results are not held up, through a two stage path: set row read, then policy and row write
// an item's row read and fields are registered when it is taken, its result when the policy stage advances
// flush-set with k dirty ways holds the result register for k results, input waits meanwhile
// rsp back-pressure stalls the policy stage and then req_tready
// synchronous reset clears the 64 row flags at once, no clearing pass

`default_nettype none
`include "set_assoc_cache_tag_lru_top_defines.svh"

module set_assoc_cache_tag_lru_top
   import sacl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // config write, index_bits
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [IB_W-1:0]        csr_data,
   // request items
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [47:0] address
   input  wire logic [ADDR_BITS-1:0]   req_tdata,
   // [2:0] mode
   input  wire logic [MODE_W-1:0]      req_tuser,
   // result items
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] hit, [3:1] way, [4] writeback_valid, [52:5] writeback_address, [55:53] zero
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   output logic                        rsp_tlast
);

   logic [IB_W-1:0]     index_bits_ff;
   logic [IB_W-1:0]     ib_eff;
   logic                accept;
   logic [TAG_W-1:0]    line_num;
   logic [SET_W-1:0]    set_in;
   logic [TAG_W-1:0]    tag_in;

   logic                s1_valid_ff;
   mode_type            s1_mode_ff;
   logic [TAG_W-1:0]    s1_tag_ff;
   logic [SET_W-1:0]    s1_set_ff;
   logic [IB_W-1:0]     s1_ib_ff;

   logic [STAMP_W-1:0]  count_ff;
   logic [STAMP_W-1:0]  count_in;
   logic                advance;
   logic                rsp_free;
   row_type             rd_row;
   row_type             new_row;
   rsp_load_type        ld;

   // config register; the user must write it only while idle, the block itself does not enforce this
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= IB_RESET;
      end else if (csr_valid) begin
         index_bits_ff <= csr_data;
      end
   end

   // clip index width to the set index width
   assign ib_eff = (index_bits_ff > IB_RESET) ? IB_RESET : index_bits_ff;

   // address split
   assign line_num = req_tdata[ADDR_BITS-1:OFF_W];
   assign set_in   = line_num[SET_W-1:0] & ~({SET_W{1'b1}} << ib_eff);
   assign tag_in   = line_num >> ib_eff;

   // policy stage moves when the result register can take its output
   assign advance    = s1_valid_ff && rsp_free;
   assign req_tready = !s1_valid_ff || rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff <= mode_type'(req_tuser);
         s1_tag_ff  <= tag_in;
         s1_set_ff  <= set_in;
         s1_ib_ff   <= ib_eff;
      end
   end

   // saturating access counter, the raised value stamps this item
   assign count_in = (count_ff == '1) ? count_ff : count_ff + STAMP_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (advance) begin
         count_ff <= count_in;
      end
   end

   sacl_row_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (set_in),
      .rd_row  (rd_row),
      .wr_en   (advance),
      .wr_addr (s1_set_ff),
      .wr_row  (new_row)
   );

   sacl_policy u_policy (
      .mode    (s1_mode_ff),
      .tag     (s1_tag_ff),
      .set_idx (s1_set_ff),
      .ib      (s1_ib_ff),
      .stamp   (count_in),
      .row     (rd_row),
      .new_row (new_row),
      .ld      (ld)
   );

   sacl_rsp_queue u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .ld         (ld),
      .ld_tags    (rd_row.tag),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // a dirty bit never survives on an invalid way
   `SACL_ASSERT_NOW(a_dirty_on_valid, clock, reset, advance, (new_row.dirty & ~new_row.valid) == '0)
   // no write-back address without a write-back
   `SACL_ASSERT_NOW(a_wba_zero, clock, reset, rsp_tvalid && !rsp_tdata[4], rsp_tdata[52:5] == '0)
   // flush results follow one another with no gap
   `SACL_ASSERT_NEXT(a_flush_run, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid)
   // access counter never steps back
   `SACL_ASSERT_NEXT(a_count_mono, clock, reset, 1'b1, count_ff >= $past(count_ff))

endmodule

`default_nettype wire
